// ===== rtl/core/sfmp_pkg.sv =====
// Shared constants, command and kind codes, and port structs for the field mask packer.
package sfmp_pkg;

  // Table geometry
  localparam int NUM_FIELDS  = 32;
  localparam int IDX_W       = $clog2(NUM_FIELDS);
  localparam int BLOCK_BITS  = 32;
  localparam int BLOCK_SHIFT = $clog2(BLOCK_BITS);
  localparam int NUM_BLOCKS  = (NUM_FIELDS + BLOCK_BITS - 1) / BLOCK_BITS;
  localparam int BLK_IDX_W   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int MASK_W      = NUM_BLOCKS * BLOCK_BITS;

  // Item field widths
  localparam int CMD_W   = 3;
  localparam int FIDX_W  = 6;
  localparam int VALUE_W = 64;
  localparam int LANE_W  = 2;
  localparam int WORD_W  = 32;
  localparam int KIND_W  = 2;

  // Table size at the width of an incoming index, plus one bit for the pair check
  localparam logic [FIDX_W:0] NUM_FIELDS_EXT = (FIDX_W + 1)'(NUM_FIELDS);

  localparam logic [WORD_W-1:0] BYTE_MASK = 32'hFF;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SET_WORD = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SET_PAIR = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SET_BYTE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_EMIT     = 3'd4;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_COUNT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MASK  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_VALUE = 2'd2;

  // Field RAM write port
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  addr;
    logic [WORD_W-1:0] data;
  } ram_wr_t;

  // Field RAM read port
  typedef struct packed {
    logic             re;
    logic [IDX_W-1:0] addr;
  } ram_rd_t;

  // Load request into the result register
  typedef struct packed {
    logic              load;
    logic [WORD_W-1:0] word;
    logic [KIND_W-1:0] kind;
    logic              last;
  } out_ld_t;

endpackage

// ===== rtl/core/sfmp_cmd_if.sv =====
// Command channel: valid/ready handshake carrying one command item.
interface sfmp_cmd_if;
  import sfmp_pkg::*;

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [FIDX_W-1:0]  field_index;
  logic [VALUE_W-1:0] value;
  logic [LANE_W-1:0]  byte_lane;

  modport source (output valid, output cmd, output field_index, output value,
                  output byte_lane, input ready);
  modport sink (input valid, input cmd, input field_index, input value,
                input byte_lane, output ready);

endinterface

// ===== rtl/core/sfmp_res_if.sv =====
// Result channel: valid/ready handshake carrying one result item.
interface sfmp_res_if;
  import sfmp_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] word;
  logic [KIND_W-1:0] kind;
  logic              last;

  modport source (output valid, output word, output kind, output last, input ready);
  modport sink (input valid, input word, input kind, input last, output ready);

endinterface

// ===== rtl/core/sfmp_field_ram.sv =====
// Field word RAM: one write port, one read port with registered read data.
module sfmp_field_ram (
  input  logic                              clk,
  input  sfmp_pkg::ram_wr_t                 wr,
  input  sfmp_pkg::ram_rd_t                 rd,
  output logic [sfmp_pkg::WORD_W-1:0]       rdata
);
  import sfmp_pkg::*;

  logic [WORD_W-1:0] mem [NUM_FIELDS];

  // Write the addressed entry
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Registered read of the addressed entry
  always_ff @(posedge clk) begin
    if (rd.re) begin
      rdata <= mem[rd.addr];
    end
  end

endmodule

// ===== rtl/core/sfmp_emit_out.sv =====
// Result holding register: takes a load when empty or draining, holds it under stall.
module sfmp_emit_out (
  input  logic              clk,
  input  logic              rst,
  input  sfmp_pkg::out_ld_t ld,
  output logic              free,
  sfmp_res_if.source        results
);
  import sfmp_pkg::*;

  logic              valid;
  logic [WORD_W-1:0] word;
  logic [KIND_W-1:0] kind;
  logic              last;

  // Room for a new item this cycle
  assign free = !valid || results.ready;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ld.load) begin
      valid <= 1'b1;
    end else if (results.ready) begin
      valid <= 1'b0;
    end
  end

  // Capture the payload
  always_ff @(posedge clk) begin
    if (ld.load) begin
      word <= ld.word;
      kind <= ld.kind;
      last <= ld.last;
    end
  end

  assign results.valid = valid;
  assign results.word  = word;
  assign results.kind  = kind;
  assign results.last  = last;

endmodule

// ===== rtl/core/sparse_field_mask_packer_core.sv =====
// Top level of the field mask packer: command sequencer, set flags and emit walk.
//
//   channel   dir  payload                                  handshake
//   cmds      in   cmd, field_index, value, byte_lane       valid / ready
//   results   out  word, kind, last                         valid / ready
//
// One command at a time. Clear, set word and ignored commands complete on acceptance; set pair makes
// two writes on one RAM write port; set byte does a RAM read, then merges and writes back.
// Emit accepts, loads the count and mask items, reads and then loads each set field (RAM read
// latency), and steps over each unset field below the highest set index.
// Synchronous reset clears set flags and the highest-index tracker; an entry without its set
// flag reads as zero. A results stall holds the walk; the output register reloads as it drains.
module sparse_field_mask_packer_core (
  input  logic       clk,
  input  logic       rst,
  sfmp_cmd_if.sink   cmds,
  sfmp_res_if.source results
);
  import sfmp_pkg::*;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_PAIR_HI = 3'd1;
  localparam logic [2:0] ST_BYTE_WR = 3'd2;
  localparam logic [2:0] ST_COUNT   = 3'd3;
  localparam logic [2:0] ST_MASK    = 3'd4;
  localparam logic [2:0] ST_SCAN    = 3'd5;
  localparam logic [2:0] ST_VAL     = 3'd6;

  logic [2:0]            state, state_next;
  logic [NUM_FIELDS-1:0] field_valid, field_valid_next;
  logic [IDX_W-1:0]      top_index, top_index_next;
  logic                  any_set, any_set_next;
  logic [IDX_W-1:0]      ptr, ptr_next;
  logic [BLK_IDX_W-1:0]  blk, blk_next;
  logic [WORD_W-1:0]     hold_word, hold_word_next;
  logic [LANE_W-1:0]     hold_lane, hold_lane_next;

  ram_wr_t           wr;
  ram_rd_t           rd;
  out_ld_t           ld;
  logic [WORD_W-1:0] rdata;
  logic              out_free;

  logic              accept;
  logic              idx_ok;
  logic              pair_ok;
  logic [IDX_W-1:0]  in_addr;
  logic              mark_en;
  logic [IDX_W-1:0]  mark_idx;
  logic [BLK_IDX_W-1:0] top_blk;
  logic [MASK_W-1:0] valid_pad;
  logic [WORD_W-1:0] old_word;
  logic [WORD_W-1:0] merged_word;
  logic [4:0]        lane_shift;

  sfmp_field_ram u_ram (
    .clk   (clk),
    .wr    (wr),
    .rd    (rd),
    .rdata (rdata)
  );

  sfmp_emit_out u_out (
    .clk     (clk),
    .rst     (rst),
    .ld      (ld),
    .free    (out_free),
    .results (results)
  );

  // Decode the incoming item
  assign cmds.ready = (state == ST_IDLE);
  assign accept     = cmds.valid && cmds.ready;
  assign idx_ok     = {1'b0, cmds.field_index} < NUM_FIELDS_EXT;
  assign pair_ok    = ({1'b0, cmds.field_index} + 7'd1) < NUM_FIELDS_EXT;
  assign in_addr    = IDX_W'(cmds.field_index);

  // Mask words and the last block index
  assign top_blk   = BLK_IDX_W'(top_index >> BLOCK_SHIFT);
  assign valid_pad = MASK_W'(field_valid);

  // Merge one byte into the stored word; an unset entry counts as zero
  assign old_word    = field_valid[ptr] ? rdata : '0;
  assign lane_shift  = {hold_lane, 3'b000};
  assign merged_word = (old_word & ~(BYTE_MASK << lane_shift)) | (hold_word << lane_shift);

  // Sequence commands and the emit walk
  always_comb begin
    state_next       = state;
    field_valid_next = field_valid;
    top_index_next   = top_index;
    any_set_next     = any_set;
    ptr_next         = ptr;
    blk_next         = blk;
    hold_word_next   = hold_word;
    hold_lane_next   = hold_lane;
    wr               = '0;
    rd               = '0;
    ld               = '0;
    mark_en          = 1'b0;
    mark_idx         = ptr;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (cmds.cmd)
            CMD_CLEAR: begin
              field_valid_next = '0;
              top_index_next   = '0;
              any_set_next     = 1'b0;
            end
            CMD_SET_WORD: begin
              if (idx_ok) begin
                wr       = '{we: 1'b1, addr: in_addr, data: cmds.value[WORD_W-1:0]};
                mark_en  = 1'b1;
                mark_idx = in_addr;
              end
            end
            CMD_SET_PAIR: begin
              if (pair_ok) begin
                wr             = '{we: 1'b1, addr: in_addr, data: cmds.value[WORD_W-1:0]};
                mark_en        = 1'b1;
                mark_idx       = in_addr;
                ptr_next       = in_addr + IDX_W'(1);
                hold_word_next = cmds.value[VALUE_W-1:WORD_W];
                state_next     = ST_PAIR_HI;
              end
            end
            CMD_SET_BYTE: begin
              if (idx_ok) begin
                rd             = '{re: 1'b1, addr: in_addr};
                ptr_next       = in_addr;
                hold_word_next = WORD_W'(cmds.value[7:0]);
                hold_lane_next = cmds.byte_lane;
                state_next     = ST_BYTE_WR;
              end
            end
            CMD_EMIT: begin
              state_next = ST_COUNT;
            end
            default: begin
            end
          endcase
        end
      end
      ST_PAIR_HI: begin
        wr         = '{we: 1'b1, addr: ptr, data: hold_word};
        mark_en    = 1'b1;
        mark_idx   = ptr;
        state_next = ST_IDLE;
      end
      ST_BYTE_WR: begin
        wr         = '{we: 1'b1, addr: ptr, data: merged_word};
        mark_en    = 1'b1;
        mark_idx   = ptr;
        state_next = ST_IDLE;
      end
      ST_COUNT: begin
        if (out_free) begin
          ld.load  = 1'b1;
          ld.word  = any_set ? (WORD_W'(top_blk) + 32'd1) : '0;
          ld.kind  = KIND_COUNT;
          ld.last  = !any_set;
          blk_next = '0;
          state_next = any_set ? ST_MASK : ST_IDLE;
        end
      end
      ST_MASK: begin
        if (out_free) begin
          ld.load = 1'b1;
          ld.word = valid_pad[blk * BLOCK_BITS +: BLOCK_BITS];
          ld.kind = KIND_MASK;
          ld.last = 1'b0;
          if (blk == top_blk) begin
            ptr_next   = '0;
            state_next = ST_SCAN;
          end else begin
            blk_next = blk + BLK_IDX_W'(1);
          end
        end
      end
      ST_SCAN: begin
        if (field_valid[ptr]) begin
          if (out_free) begin
            rd         = '{re: 1'b1, addr: ptr};
            state_next = ST_VAL;
          end
        end else begin
          ptr_next = ptr + IDX_W'(1);
        end
      end
      ST_VAL: begin
        ld.load = 1'b1;
        ld.word = rdata;
        ld.kind = KIND_VALUE;
        ld.last = (ptr == top_index);
        if (ptr == top_index) begin
          state_next = ST_IDLE;
        end else begin
          ptr_next   = ptr + IDX_W'(1);
          state_next = ST_SCAN;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // Flag a written field and advance the highest set index
    if (mark_en) begin
      field_valid_next[mark_idx] = 1'b1;
      if (!any_set || (mark_idx > top_index)) begin
        top_index_next = mark_idx;
      end
      any_set_next = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      field_valid <= '0;
      top_index   <= '0;
      any_set     <= 1'b0;
    end else begin
      state       <= state_next;
      field_valid <= field_valid_next;
      top_index   <= top_index_next;
      any_set     <= any_set_next;
    end
  end

  // Walk pointers and held operands
  always_ff @(posedge clk) begin
    ptr       <= ptr_next;
    blk       <= blk_next;
    hold_word <= hold_word_next;
    hold_lane <= hold_lane_next;
  end

  // A load never lands on a held result
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    ld.load |-> out_free)
    else $error("result register loaded while full");

  // An empty table has no set flags
  a_empty_clear: assert property (@(posedge clk) disable iff (rst)
    !any_set |-> (field_valid == '0))
    else $error("set flag present with empty table");

  // The highest set index is itself set
  a_top_set: assert property (@(posedge clk) disable iff (rst)
    any_set |-> field_valid[top_index])
    else $error("highest index not flagged");

  // Value output follows a RAM read
  a_val_read: assert property (@(posedge clk) disable iff (rst)
    (state == ST_VAL) |-> $past(rd.re))
    else $error("value emitted without a RAM read");

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the sparse field mask packer: directed and random command items.
`timescale 1ns / 1ps

module tb_top;
  import sfmp_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam longint LIMIT_CYCLES = 1_000_000;
  localparam int RANDOM_ITEMS = 500;
  localparam int MAX_WAIT     = 13;
  localparam int TAIL_CYCLES  = 40;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AFTER   = 300;

  // Command codes the block must ignore
  localparam logic [CMD_W-1:0] CMD_RSVD_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD_LAST  = 3'd7;

  typedef struct {
    logic [CMD_W-1:0]   cmd;
    logic [FIDX_W-1:0]  field_index;
    logic [VALUE_W-1:0] value;
    logic [LANE_W-1:0]  byte_lane;
    bit                 drain;
  } cmd_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [KIND_W-1:0] kind;
    logic              last;
  } emit_word_t;

  logic clk;
  logic rst;
  logic hold_off = 1'b0;

  sfmp_cmd_if cmds_if ();
  sfmp_res_if res_if ();

  sparse_field_mask_packer_core u_dut (
    .clk     (clk),
    .rst     (rst),
    .cmds    (cmds_if),
    .results (res_if)
  );

  // Predicted table contents
  logic [WORD_W-1:0] tbl_word [NUM_FIELDS];
  bit                tbl_set  [NUM_FIELDS];
  logic [5:0]        tbl_top;
  bit                tbl_any;

  cmd_item_t  cmd_items_to_send [$];
  emit_word_t emit_due [$];
  cmd_item_t  in_flight;
  emit_word_t oldest_due;

  int unsigned items_total;
  int unsigned items_accepted = 0;
  int unsigned fail_count = 0;
  int unsigned tx_wait = 0;
  int unsigned rx_wait = 0;
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic void clear_table();
    for (int i = 0; i < NUM_FIELDS; i++) begin
      tbl_word[i] = '0;
      tbl_set[i]  = 1'b0;
    end
    tbl_top = '0;
    tbl_any = 1'b0;
  endfunction

  function automatic void mark_field(input int idx);
    tbl_set[idx] = 1'b1;
    if (!tbl_any || idx > int'(tbl_top)) tbl_top = 6'(idx);
    tbl_any = 1'b1;
  endfunction

  // Update the table for one accepted item and queue the words an emit produces
  function automatic void apply_field_cmd(input cmd_item_t it);
    emit_word_t  run [$];
    int          idx;
    int unsigned count;
    int unsigned blocks;
    logic [WORD_W-1:0] m;
    idx = int'(it.field_index);
    case (it.cmd)
      CMD_CLEAR: clear_table();
      CMD_SET_WORD: begin
        if (idx < NUM_FIELDS) begin
          tbl_word[idx] = it.value[WORD_W-1:0];
          mark_field(idx);
        end
      end
      CMD_SET_PAIR: begin
        if (idx + 1 < NUM_FIELDS) begin
          tbl_word[idx]     = it.value[WORD_W-1:0];
          tbl_word[idx + 1] = it.value[VALUE_W-1:WORD_W];
          mark_field(idx);
          mark_field(idx + 1);
        end
      end
      CMD_SET_BYTE: begin
        if (idx < NUM_FIELDS) begin
          tbl_word[idx][8 * it.byte_lane +: 8] = it.value[7:0];
          mark_field(idx);
        end
      end
      CMD_EMIT: begin
        count = tbl_any ? int'(tbl_top) + 1 : 0;
        if (count > NUM_FIELDS) count = NUM_FIELDS;
        blocks = (count + BLOCK_BITS - 1) / BLOCK_BITS;
        run.push_back('{word: WORD_W'(blocks), kind: KIND_COUNT, last: 1'b0});
        for (int b = 0; b < blocks; b++) begin
          m = '0;
          for (int j = 0; j < BLOCK_BITS; j++) begin
            if (b * BLOCK_BITS + j < count && tbl_set[b * BLOCK_BITS + j]) m[j] = 1'b1;
          end
          run.push_back('{word: m, kind: KIND_MASK, last: 1'b0});
        end
        for (int i = 0; i < count; i++) begin
          if (tbl_set[i]) run.push_back('{word: tbl_word[i], kind: KIND_VALUE, last: 1'b0});
        end
        run[run.size() - 1].last = 1'b1;
        foreach (run[k]) emit_due.push_back(run[k]);
      end
      default: ;
    endcase
  endfunction

  function automatic void queue_cmd(input logic [CMD_W-1:0] c, input int unsigned idx,
                                    input logic [VALUE_W-1:0] v, input int unsigned lane,
                                    input bit drain = 1'b0);
    cmd_item_t it;
    it.cmd         = c;
    it.field_index = FIDX_W'(idx);
    it.value       = v;
    it.byte_lane   = LANE_W'(lane);
    it.drain       = drain;
    cmd_items_to_send.push_back(it);
  endfunction

  function automatic logic [VALUE_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0: return '1;
      1: return '0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Mostly in-range indexes, some beyond the table
  function automatic int unsigned rand_index();
    if ($urandom_range(0, 6) == 0) return $urandom_range(0, 63);
    return $urandom_range(0, NUM_FIELDS - 1);
  endfunction

  function automatic int unsigned draw_wait(input bit idle_on);
    return idle_on ? $urandom_range(0, MAX_WAIT) : 0;
  endfunction

  // Command driver: present queued items, hold each until accepted
  always @(posedge clk) begin
    if (rst) begin
      cmds_if.valid <= 1'b0;
      tx_wait = 0;
    end else begin
      if (cmds_if.valid && cmds_if.ready) begin
        apply_field_cmd(in_flight);
        items_accepted++;
        if ($urandom_range(0, 39) == 0) tx_idle_on = !tx_idle_on;
        tx_wait = draw_wait(tx_idle_on);
      end
      if (!cmds_if.valid || cmds_if.ready) begin
        if (tx_wait > 0) begin
          tx_wait--;
          cmds_if.valid <= 1'b0;
        end else if (cmd_items_to_send.size() != 0 &&
                     !(cmd_items_to_send[0].drain && emit_due.size() != 0)) begin
          in_flight = cmd_items_to_send.pop_front();
          cmds_if.valid       <= 1'b1;
          cmds_if.cmd         <= in_flight.cmd;
          cmds_if.field_index <= in_flight.field_index;
          cmds_if.value       <= in_flight.value;
          cmds_if.byte_lane   <= in_flight.byte_lane;
        end else begin
          cmds_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each accepted item with the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (emit_due.size() == 0) begin
          $error("unexpected result: word %h kind %0d last %0b",
                 res_if.word, res_if.kind, res_if.last);
          fail_count++;
        end else begin
          oldest_due = emit_due.pop_front();
          if (res_if.word !== oldest_due.word) begin
            $error("word: expected %h, actual %h", oldest_due.word, res_if.word);
            fail_count++;
          end
          if (res_if.kind !== oldest_due.kind) begin
            $error("kind: expected %0d, actual %0d", oldest_due.kind, res_if.kind);
            fail_count++;
          end
          if (res_if.last !== oldest_due.last) begin
            $error("last: expected %0b, actual %0b", oldest_due.last, res_if.last);
            fail_count++;
          end
        end
        if ($urandom_range(0, 39) == 0) rx_idle_on = !rx_idle_on;
        rx_wait = draw_wait(rx_idle_on);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      res_if.ready <= (rx_wait == 0) && !hold_off;
    end
  end

  // Block the result side for a long stretch while commands keep coming
  initial begin
    while (items_accepted < HOLD_AFTER) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int unsigned rnd_items;
    int unsigned seq_len;
    bit          drained_once;
    logic [CMD_W-1:0] op;
    rst                 = 1'b1;
    cmds_if.valid       = 1'b0;
    cmds_if.cmd         = CMD_CLEAR;
    cmds_if.field_index = '0;
    cmds_if.value       = '0;
    cmds_if.byte_lane   = '0;
    res_if.ready        = 1'b0;
    clear_table();

    // Empty table, edge indexes, pair at and past the end, every byte lane
    queue_cmd(CMD_EMIT, 0, '0, 0);
    queue_cmd(CMD_SET_WORD, 0, 64'hFFFF_FFFF_FFFF_FFFF, 3);
    queue_cmd(CMD_SET_WORD, NUM_FIELDS - 1, '0, 0);
    queue_cmd(CMD_SET_WORD, NUM_FIELDS, 64'h1234_5678_9ABC_DEF0, 1);
    queue_cmd(CMD_SET_WORD, 63, '1, 2);
    queue_cmd(CMD_SET_PAIR, NUM_FIELDS - 2, 64'h8000_0001_FFFF_FFFE, 0);
    queue_cmd(CMD_SET_PAIR, NUM_FIELDS - 1, 64'h5555_5555_AAAA_AAAA, 0);
    queue_cmd(CMD_SET_PAIR, 63, '1, 0);
    queue_cmd(CMD_SET_BYTE, 5, 64'hFFFF_FFFF_FFFF_FFAB, 0);
    queue_cmd(CMD_SET_BYTE, 5, 64'h0000_0000_0000_00CD, 1);
    queue_cmd(CMD_SET_BYTE, 5, 64'hFFFF_FFFF_FFFF_FF00, 2);
    queue_cmd(CMD_SET_BYTE, 5, 64'h0000_0000_0000_00FF, 3);
    queue_cmd(CMD_SET_BYTE, 40, '1, 3);
    for (int c = CMD_RSVD_FIRST; c <= CMD_RSVD_LAST; c++) queue_cmd(CMD_W'(c), 1, '1, 1);
    queue_cmd(CMD_EMIT, 63, '1, 3);
    queue_cmd(CMD_CLEAR, 0, '0, 0);
    queue_cmd(CMD_EMIT, 0, '0, 0);
    // Merge into a cleared word, then a low top index
    queue_cmd(CMD_SET_BYTE, 0, 64'h0000_0000_0000_0077, 3);
    queue_cmd(CMD_EMIT, 0, '0, 0);
    queue_cmd(CMD_SET_PAIR, 0, '0, 0);
    queue_cmd(CMD_SET_WORD, 16, 64'h0000_0000_DEAD_BEEF, 0, 1'b1);
    queue_cmd(CMD_EMIT, 0, '0, 0);

    // Random runs: optional clear, one to eight sets or reserved commands, then an emit
    rnd_items    = 0;
    drained_once = 1'b0;
    while (rnd_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        queue_cmd(CMD_CLEAR, $urandom_range(0, 63), rand_value(), $urandom_range(0, 3));
        rnd_items++;
      end
      seq_len = $urandom_range(1, 8);
      repeat (seq_len) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: op = CMD_SET_WORD;
          4, 5:       op = CMD_SET_PAIR;
          6, 7, 8:    op = CMD_SET_BYTE;
          default:    op = CMD_W'(int'(CMD_RSVD_FIRST) +
                                  $urandom_range(0, CMD_RSVD_LAST - CMD_RSVD_FIRST));
        endcase
        queue_cmd(op, rand_index(), rand_value(), $urandom_range(0, 3));
        rnd_items++;
      end
      // Once, let every pending result drain before the next emit
      queue_cmd(CMD_EMIT, $urandom_range(0, 63), rand_value(), $urandom_range(0, 3),
                !drained_once && rnd_items >= RANDOM_ITEMS / 2);
      if (rnd_items >= RANDOM_ITEMS / 2) drained_once = 1'b1;
      rnd_items++;
    end
    items_total = cmd_items_to_send.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (items_accepted < items_total) @(posedge clk);
    while (emit_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
